/* src/edb_pkg.sv */
// ----------------------------------------------------------------------------
// edb_pkg: shared types, constants and helpers of the error diffusion binarizer
// Sizes of the window, fixed-point formats, diffusion weights and register
// indexes used by the cells, the line store and the top level.
// ----------------------------------------------------------------------------
package edb_pkg;

  // Largest supported window
  localparam int MAX_WIDTH = 128;
  localparam int MAX_ROWS  = 64;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Register field widths
  localparam int LW_W  = 8;
  localparam int FR_W  = 7;
  localparam int THR_W = 8;
  localparam int PIX_W = 8;

  localparam logic [LW_W-1:0]  LW_RESET  = 8'd128;
  localparam logic [FR_W-1:0]  FR_RESET  = 7'd64;
  localparam logic [THR_W-1:0] THR_RESET = 8'd128;

  // Errors: signed, 4 fraction bits, saturating 14-bit store
  localparam int ERR_W = 14;
  localparam int ADJ_W = 16;  // pixel*16 plus error, and the quantization error
  localparam int SUM_W = 20;  // room for error*7 and accumulation

  localparam logic signed [ERR_W-1:0] ERR_MAX = 14'sh1FFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 14'sh2000;

  localparam logic signed [ADJ_W-1:0] WHITE_LEVEL = 16'sd4080;  // 255 * 16

  // Floyd-Steinberg weights, in sixteenths
  localparam logic [2:0] W_RIGHT       = 3'd7;
  localparam logic [2:0] W_BELOW_LEFT  = 3'd3;
  localparam logic [2:0] W_BELOW       = 3'd5;
  localparam logic [2:0] W_BELOW_RIGHT = 3'd1;

  typedef enum logic [1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_FRAME_ROWS = 2'd1,
    CFG_THRESHOLD  = 2'd2
  } cfg_idx_e;

  // One write into the line store
  typedef struct packed {
    logic                    en;
    logic [COL_W-1:0]        addr;
    logic signed [ERR_W-1:0] data;
  } wr_req_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > SUM_W'(ERR_MAX)) begin
      r = ERR_MAX;
    end else if (v < SUM_W'(ERR_MIN)) begin
      r = ERR_MIN;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/edb_cell.sv */
// ----------------------------------------------------------------------------
// edb_cell: one diffusion tap
// Scales the quantization error by its weight in sixteenths (floor), adds it
// to the error handed on by the neighbor tap and saturates to the store width.
// ----------------------------------------------------------------------------
module edb_cell (
  input  logic signed [edb_pkg::ERR_W-1:0] acc_i,
  input  logic signed [edb_pkg::ADJ_W-1:0] err_i,
  input  logic        [2:0]                weight_i,
  output logic signed [edb_pkg::ERR_W-1:0] acc_o
);

  logic signed [edb_pkg::SUM_W-1:0] prod;
  logic signed [edb_pkg::SUM_W-1:0] share;
  logic signed [edb_pkg::SUM_W-1:0] sum;

  always_comb begin
    prod  = edb_pkg::SUM_W'(err_i) * edb_pkg::SUM_W'($signed({1'b0, weight_i}));
    share = prod >>> 4;  // floor toward minus infinity
    sum   = edb_pkg::SUM_W'(acc_i) + share;
    acc_o = edb_pkg::sat_err(sum);
  end

endmodule

/* src/edb_line_store.sv */
// ----------------------------------------------------------------------------
// edb_line_store: next-row error line
// One entry per column, one write and one registered read per cycle. Valid
// bits clear every entry together at frame end; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module edb_line_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  edb_pkg::wr_req_t                 wr_i,
  input  logic                             rd_en_i,
  input  logic        [edb_pkg::COL_W-1:0] rd_addr_i,
  output logic signed [edb_pkg::ERR_W-1:0] rd_data_o
);

  logic signed [edb_pkg::ERR_W-1:0] mem_q [edb_pkg::MAX_WIDTH];
  logic signed [edb_pkg::ERR_W-1:0] rd_q;
  logic [edb_pkg::MAX_WIDTH-1:0]    vld_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
      if (clear_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* src/error_diffusion_binarizer.sv */
// ----------------------------------------------------------------------------
// error_diffusion_binarizer: Floyd-Steinberg 1-bit dithering of a grey window
// Takes 8-bit pixels in raster order, returns one black/white bit per pixel
// with its column, row and a frame-end flag.
//
//   channel  | signals                                    | dir
//   ---------+--------------------------------------------+-----
//   pixel in | in_valid_i, in_ready_o, pixel_i            | in
//   result   | out_valid_o, out_ready_i, black_o,         | out
//            | column_o, row_o, frame_end_o               |
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i,     | in
//            | cfg_data_i                                 |
//
// One item per cycle while results are taken; an item passes the compute
// stage and then the output register. The rate is set by the right-neighbor
// error loop, which closes through the compute stage and the right-carry register.
// Reset loads the register defaults and clears all error; no clearing pass.
// A stalled result holds in the output register; the compute stage still
// takes one more item, and input ready drops only while both are full.
// Config writes are always taken and act at once.
// ----------------------------------------------------------------------------
module error_diffusion_binarizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic        [edb_pkg::PIX_W-1:0]  pixel_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              black_o,
  output logic        [edb_pkg::COL_W-1:0]  column_o,
  output logic        [edb_pkg::ROW_W-1:0]  row_o,
  output logic                              frame_end_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [1:0]                 cfg_index_i,
  input  logic        [edb_pkg::LW_W-1:0]   cfg_data_i
);

  // widths wide enough for both the register field and the window size
  localparam int LWX_W = (edb_pkg::LW_W > edb_pkg::COL_W + 1) ?
                         edb_pkg::LW_W : edb_pkg::COL_W + 1;
  localparam int FRX_W = (edb_pkg::FR_W > edb_pkg::ROW_W + 1) ?
                         edb_pkg::FR_W : edb_pkg::ROW_W + 1;

  // ---- configuration registers
  logic [edb_pkg::LW_W-1:0]  lw_q;
  logic [edb_pkg::FR_W-1:0]  fr_q;
  logic [edb_pkg::THR_W-1:0] thr_q;

  // ---- position counters (next pixel)
  logic [edb_pkg::COL_W-1:0] col_q, col_d;
  logic [edb_pkg::ROW_W-1:0] row_q, row_d;

  // ---- compute stage
  logic                             s1_vld_q, s1_vld_d;
  logic [edb_pkg::PIX_W-1:0]        s1_pix_q;
  logic [edb_pkg::COL_W-1:0]        s1_col_q;
  logic [edb_pkg::ROW_W-1:0]        s1_row_q;
  logic                             s1_lc_q;
  logic                             s1_lr_q;
  logic                             fwd_hit_q, fwd_hit_d;
  logic signed [edb_pkg::ERR_W-1:0] fwd_val_q, fwd_val_d;

  // ---- diffusion state: carry to the right, two next-row partial sums
  logic signed [edb_pkg::ERR_W-1:0] rc_q, rc_d;
  logic signed [edb_pkg::ERR_W-1:0] p0_q, p0_d;
  logic signed [edb_pkg::ERR_W-1:0] p1_q, p1_d;

  // last-column entry of the line, written on the next (column 0) item
  logic signed [edb_pkg::ERR_W-1:0] tail_q, tail_d;
  logic [edb_pkg::COL_W-1:0]        tail_addr_q, tail_addr_d;
  logic                             tail_pend_q, tail_pend_d;

  // ---- output register
  logic                      out_vld_q, out_vld_d;
  logic                      out_black_q;
  logic [edb_pkg::COL_W-1:0] out_col_q;
  logic [edb_pkg::ROW_W-1:0] out_row_q;
  logic                      out_fe_q;

  // ---- combinational
  logic                             accept;
  logic                             adv;
  logic                             frame_clear;
  logic [LWX_W-1:0]                 lw_x;
  logic [FRX_W-1:0]                 fr_x;
  logic [edb_pkg::COL_W-1:0]        w_m1;
  logic [edb_pkg::ROW_W-1:0]        h_m1;
  logic [edb_pkg::COL_W-1:0]        c_now;
  logic                             lc_now;
  logic                             lr_now;
  logic signed [edb_pkg::ERR_W-1:0] st_rd_data;
  logic signed [edb_pkg::ERR_W-1:0] head;
  logic signed [edb_pkg::ERR_W-1:0] cur;
  logic signed [edb_pkg::ADJ_W-1:0] adj;
  logic signed [edb_pkg::ADJ_W-1:0] thr16;
  logic signed [edb_pkg::ADJ_W-1:0] qerr;
  logic                             black;
  logic signed [edb_pkg::ERR_W-1:0] rc_new;
  logic signed [edb_pkg::ERR_W-1:0] p1_new;
  logic signed [edb_pkg::ERR_W-1:0] p0_new;
  logic signed [edb_pkg::ERR_W-1:0] bl_val;
  edb_pkg::wr_req_t                 wr;

  // ---- handshakes
  assign cfg_ready_o = 1'b1;
  assign adv         = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !s1_vld_q || adv;
  assign accept      = in_valid_i && in_ready_o;
  assign frame_clear = adv && s1_lc_q && s1_lr_q;

  // ---- window size with out-of-range register values folded in
  always_comb begin
    lw_x = LWX_W'(lw_q);
    fr_x = FRX_W'(fr_q);
    if (lw_x == '0) begin
      w_m1 = '0;
    end else if (lw_x > LWX_W'(edb_pkg::MAX_WIDTH)) begin
      w_m1 = edb_pkg::COL_W'(edb_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = edb_pkg::COL_W'(lw_x - 1'b1);
    end
    if (fr_x == '0) begin
      h_m1 = '0;
    end else if (fr_x > FRX_W'(edb_pkg::MAX_ROWS)) begin
      h_m1 = edb_pkg::ROW_W'(edb_pkg::MAX_ROWS - 1);
    end else begin
      h_m1 = edb_pkg::ROW_W'(fr_x - 1'b1);
    end
  end

  // position of the item being taken; a counter left past the edge by a
  // width write is treated as the last column
  always_comb begin
    c_now  = (col_q > w_m1) ? w_m1 : col_q;
    lc_now = (c_now == w_m1);
    lr_now = (row_q >= h_m1);
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (lc_now) begin
        col_d = '0;
        row_d = lr_now ? '0 : edb_pkg::ROW_W'(row_q + 1'b1);
      end else begin
        col_d = edb_pkg::COL_W'(c_now + 1'b1);
      end
    end
  end

  // ---- quantize
  always_comb begin
    head  = fwd_hit_q ? fwd_val_q : st_rd_data;
    cur   = edb_pkg::sat_err(edb_pkg::SUM_W'(head) + edb_pkg::SUM_W'(rc_q));
    adj   = edb_pkg::ADJ_W'(cur) + $signed({4'b0000, s1_pix_q, 4'b0000});
    thr16 = $signed({4'b0000, thr_q, 4'b0000});
    black = (adj < thr16);
    qerr  = black ? adj : adj - edb_pkg::WHITE_LEVEL;
  end

  // ---- diffusion taps: right -> carry; below-right -> below -> below-left -> line store
  edb_cell u_cell_right (
    .acc_i    ('0),
    .err_i    (qerr),
    .weight_i (edb_pkg::W_RIGHT),
    .acc_o    (rc_new)
  );

  edb_cell u_cell_below_right (
    .acc_i    ('0),
    .err_i    (qerr),
    .weight_i (edb_pkg::W_BELOW_RIGHT),
    .acc_o    (p1_new)
  );

  edb_cell u_cell_below (
    .acc_i    (p1_q),
    .err_i    (qerr),
    .weight_i (edb_pkg::W_BELOW),
    .acc_o    (p0_new)
  );

  edb_cell u_cell_below_left (
    .acc_i    (p0_q),
    .err_i    (qerr),
    .weight_i (edb_pkg::W_BELOW_LEFT),
    .acc_o    (bl_val)
  );

  // ---- line store write: column c-1 completes, or on column 0 the
  // deferred last-column entry of the previous row goes in
  always_comb begin
    wr.en   = adv && ((s1_col_q != '0) || tail_pend_q);
    wr.addr = (s1_col_q != '0) ? edb_pkg::COL_W'(s1_col_q - 1'b1) : tail_addr_q;
    wr.data = (s1_col_q != '0) ? bl_val : tail_q;
  end

  edb_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (frame_clear),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (c_now),
    .rd_data_o (st_rd_data)
  );

  // ---- bypass for the entry the new item reads, when it is written or cleared in
  // the same cycle or still parked in the tail register
  always_comb begin
    fwd_hit_d = 1'b1;
    fwd_val_d = '0;
    if (frame_clear) begin
      fwd_val_d = '0;
    end else if (adv && s1_lc_q && (s1_col_q == c_now)) begin
      fwd_val_d = p0_new;
    end else if (wr.en && (wr.addr == c_now)) begin
      fwd_val_d = wr.data;
    end else if (tail_pend_q && (tail_addr_q == c_now)) begin
      fwd_val_d = tail_q;
    end else begin
      fwd_hit_d = 1'b0;
    end
  end

  // ---- diffusion state update
  always_comb begin
    rc_d        = rc_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    tail_d      = tail_q;
    tail_addr_d = tail_addr_q;
    tail_pend_d = tail_pend_q;
    if (adv) begin
      if (s1_col_q == '0) begin
        tail_pend_d = 1'b0;
      end
      if (frame_clear) begin
        rc_d        = '0;
        p0_d        = '0;
        p1_d        = '0;
        tail_pend_d = 1'b0;
      end else if (s1_lc_q) begin
        rc_d        = '0;
        p0_d        = '0;
        p1_d        = '0;
        tail_d      = p0_new;
        tail_addr_d = s1_col_q;
        tail_pend_d = 1'b1;
      end else begin
        rc_d = rc_new;
        p0_d = p0_new;
        p1_d = p1_new;
      end
    end
  end

  // ---- stage valids
  always_comb begin
    s1_vld_d = accept ? 1'b1 : (adv ? 1'b0 : s1_vld_q);
    out_vld_d = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q        <= edb_pkg::LW_RESET;
      fr_q        <= edb_pkg::FR_RESET;
      thr_q       <= edb_pkg::THR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      s1_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      rc_q        <= '0;
      p0_q        <= '0;
      p1_q        <= '0;
      tail_pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (edb_pkg::cfg_idx_e'(cfg_index_i))
          edb_pkg::CFG_LINE_WIDTH: lw_q  <= cfg_data_i;
          edb_pkg::CFG_FRAME_ROWS: fr_q  <= cfg_data_i[edb_pkg::FR_W-1:0];
          edb_pkg::CFG_THRESHOLD:  thr_q <= cfg_data_i;
          default: ;  // unused index
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      s1_vld_q    <= s1_vld_d;
      out_vld_q   <= out_vld_d;
      if (accept) begin
        fwd_hit_q <= fwd_hit_d;
      end
      rc_q        <= rc_d;
      p0_q        <= p0_d;
      p1_q        <= p1_d;
      tail_pend_q <= tail_pend_d;
    end
  end

  // ---- payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= c_now;
      s1_row_q  <= row_q;
      s1_lc_q   <= lc_now;
      s1_lr_q   <= lr_now;
      fwd_val_q <= fwd_val_d;
    end
    tail_q      <= tail_d;
    tail_addr_q <= tail_addr_d;
    if (adv) begin
      out_black_q <= black;
      out_col_q   <= s1_col_q;
      out_row_q   <= s1_row_q;
      out_fe_q    <= s1_lc_q && s1_lr_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign black_o     = out_black_q;
  assign column_o    = out_col_q;
  assign row_o       = out_row_q;
  assign frame_end_o = out_fe_q;

endmodule

/* src/edb_checker.sv */
// ----------------------------------------------------------------------------
// edb_checker: port-level checks of the error diffusion binarizer
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module edb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             black_o,
  input logic        [edb_pkg::COL_W-1:0] column_o,
  input logic        [edb_pkg::ROW_W-1:0] row_o,
  input logic                             frame_end_o
);

  // set when the last result taken closed a frame (or nothing was taken yet)
  logic after_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_fe_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      after_fe_q <= frame_end_o;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(black_o) &&
      $stable(column_o) && $stable(row_o) && $stable(frame_end_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output stall");

  // a result appearing from empty matches an item taken earlier through the compute stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching item");

  // the first pixel of each frame sits at the window origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && after_fe_q |-> column_o == '0 && row_o == '0)
    else $error("frame does not start at column 0, row 0");

endmodule

bind error_diffusion_binarizer edb_checker u_edb_checker (.*);
